@@ rtl/ata_pkg.sv @@
// ----------------------------------------------------------------------------
// ata_pkg
// Shared types, widths and helpers of the antibody titre accumulator.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned MAP_W    = 16;
  localparam int unsigned STRAIN_W = 6;
  localparam int unsigned TITRE_W  = 24;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned FRAC_W   = 17;  // Q1.16 value in [0, 1.0]
  localparam int unsigned MUL_A_W  = 33;
  localparam int unsigned MUL_B_W  = 17;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned CONTRIB_W = PROD_W - 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TITRE_W-1:0] TITRE_MAX = '1;
  localparam logic [FRAC_W-1:0]  ONE_Q16   = FRAC_W'(1) << 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEN_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WANE_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMP_TIME  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEN,
    S_WAN,
    S_LT,
    S_SGMS,
    S_ST,
    S_FIN,
    S_ACC,
    S_EMIT
  } state_t;

  // operand selection of the shared multiplier
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEN,
    OP_WAN,
    OP_LT,
    OP_SGMS,
    OP_ST,
    OP_FIN
  } op_sel_t;

  typedef struct packed {
    op_sel_t op;
    logic    in_ready;
    logic    capture;
    logic    sen_ld;
    logic    wan_ld;
    logic    lt_ld;
    logic    acc_ld;
    logic    emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic counted;
    logic last_in;
    logic last_r;
    logic out_free;
  } stat_t;

  // max(0, 1.0 - p) with p in Q16.16
  function automatic logic [FRAC_W-1:0] clamp_one_minus(input logic [31:0] p);
    logic [FRAC_W-1:0] res;
    if (p >= 32'(ONE_Q16)) begin
      res = '0;
    end else begin
      res = ONE_Q16 - p[FRAC_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/ata_in_if.sv @@
// ----------------------------------------------------------------------------
// ata_in_if
// Input channel: one infecting strain per item.
// ----------------------------------------------------------------------------
interface ata_in_if;
  logic                          valid;
  logic                          ready;
  logic [ata_pkg::TIME_W-1:0]    isolation_time;
  logic                          infected;
  logic [ata_pkg::MAP_W-1:0]     map_long;
  logic [ata_pkg::MAP_W-1:0]     map_short;
  logic [ata_pkg::STRAIN_W-1:0]  tested_strain;
  logic                          last;

  modport source (
    output valid, isolation_time, infected, map_long, map_short, tested_strain, last,
    input  ready
  );
  modport sink (
    input  valid, isolation_time, infected, map_long, map_short, tested_strain, last,
    output ready
  );
endinterface

@@ rtl/ata_out_if.sv @@
// ----------------------------------------------------------------------------
// ata_out_if
// Result channel: one titre per run.
// ----------------------------------------------------------------------------
interface ata_out_if;
  logic                          valid;
  logic                          ready;
  logic [ata_pkg::TITRE_W-1:0]   titre;
  logic [ata_pkg::STRAIN_W-1:0]  titre_strain;

  modport source (
    output valid, titre, titre_strain,
    input  ready
  );
  modport sink (
    input  valid, titre, titre_strain,
    output ready
  );
endinterface

@@ rtl/ata_mul.sv @@
// ----------------------------------------------------------------------------
// ata_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ata_mul (
  input  logic                         clk,
  input  logic [ata_pkg::MUL_A_W-1:0]  op_a,
  input  logic [ata_pkg::MUL_B_W-1:0]  op_b,
  output logic [ata_pkg::PROD_W-1:0]   prod_r
);

  logic [ata_pkg::PROD_W-1:0] prod_nxt;

  always_comb begin
    prod_nxt = ata_pkg::PROD_W'(op_a) * ata_pkg::PROD_W'(op_b);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

@@ rtl/ata_ctrl.sv @@
// ----------------------------------------------------------------------------
// ata_ctrl
// Sequencer that steps the shared multiplier through one strain item.
// ----------------------------------------------------------------------------
module ata_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  ata_pkg::stat_t  stat,
  output ata_pkg::state_t state_r,
  output ata_pkg::ctrl_t  ctrl
);

  ata_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ata_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ata_pkg::S_IDLE: begin
        if (stat.in_valid) begin
          if (stat.counted) begin
            state_nxt = ata_pkg::S_SEN;
          end else if (stat.last_in) begin
            state_nxt = ata_pkg::S_EMIT;
          end
        end
      end
      ata_pkg::S_SEN:  state_nxt = ata_pkg::S_WAN;
      ata_pkg::S_WAN:  state_nxt = ata_pkg::S_LT;
      ata_pkg::S_LT:   state_nxt = ata_pkg::S_SGMS;
      ata_pkg::S_SGMS: state_nxt = ata_pkg::S_ST;
      ata_pkg::S_ST:   state_nxt = ata_pkg::S_FIN;
      ata_pkg::S_FIN:  state_nxt = ata_pkg::S_ACC;
      ata_pkg::S_ACC: begin
        state_nxt = stat.last_r ? ata_pkg::S_EMIT : ata_pkg::S_IDLE;
      end
      ata_pkg::S_EMIT: begin
        if (stat.out_free) begin
          state_nxt = ata_pkg::S_IDLE;
        end
      end
      default: state_nxt = ata_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.op = ata_pkg::OP_NONE;
    unique case (state_r)
      ata_pkg::S_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.capture  = stat.in_valid;
      end
      ata_pkg::S_SEN:  ctrl.op = ata_pkg::OP_SEN;
      ata_pkg::S_WAN: begin
        ctrl.op     = ata_pkg::OP_WAN;
        ctrl.sen_ld = 1'b1;
      end
      ata_pkg::S_LT: begin
        ctrl.op     = ata_pkg::OP_LT;
        ctrl.wan_ld = 1'b1;
      end
      ata_pkg::S_SGMS: begin
        ctrl.op    = ata_pkg::OP_SGMS;
        ctrl.lt_ld = 1'b1;
      end
      ata_pkg::S_ST:   ctrl.op = ata_pkg::OP_ST;
      ata_pkg::S_FIN:  ctrl.op = ata_pkg::OP_FIN;
      ata_pkg::S_ACC:  ctrl.acc_ld = 1'b1;
      ata_pkg::S_EMIT: ctrl.emit = stat.out_free;
      default: ctrl = '0;
    endcase
  end

endmodule

@@ rtl/antibody_titre_accumulator.sv @@
// ----------------------------------------------------------------------------
// antibody_titre_accumulator
// Sums the titre contributions of the infecting strains of one tested strain.
// ----------------------------------------------------------------------------
// Usage: infecting strains arrive on in_ch one item at a time, in order; the
// item with last set closes the run and one titre item leaves on out_ch.
// Configuration (gains, rates, sampling time) is written through cfg_we,
// cfg_index and cfg_data while no run is in flight; other indexes are ignored.
// A counted infection keeps in_ch.ready low from acceptance until it is done:
// six products go one after another through a single shared multiplier,
// with a clamp or add step between them, and an accumulate step follows.
// An item that does not count (not infected, or isolated after the sampling
// time) leaves in_ch.ready high unless it is a last item. A last item waits
// in the emit state until the output register is free and then loads it;
// its titre shows on out_ch from that register. The output register holds
// the titre while out_ch.ready is low; in_ch keeps taking items of the next
// run meanwhile, and only the next last item waits for the register to drain.
// Reset (rst_n low, synchronous) zeroes the configuration registers, the
// state, the count and running titre of the run, and the output valid.
// ----------------------------------------------------------------------------
module antibody_titre_accumulator (
  input  logic                            clk,
  input  logic                            rst_n,
  ata_in_if.sink                          in_ch,
  ata_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ata_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ata_pkg::CFG_W-1:0]       cfg_data
);

  // configuration
  logic [ata_pkg::CFG_W-1:0] long_gain_r;
  logic [ata_pkg::CFG_W-1:0] short_gain_r;
  logic [ata_pkg::CFG_W-1:0] sen_rate_r;
  logic [ata_pkg::CFG_W-1:0] wane_rate_r;
  logic [ata_pkg::CFG_W-1:0] samp_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_gain_r  <= '0;
      short_gain_r <= '0;
      sen_rate_r   <= '0;
      wane_rate_r  <= '0;
      samp_time_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ata_pkg::REG_LONG_GAIN:  long_gain_r  <= cfg_data;
        ata_pkg::REG_SHORT_GAIN: short_gain_r <= cfg_data;
        ata_pkg::REG_SEN_RATE:   sen_rate_r   <= cfg_data;
        ata_pkg::REG_WANE_RATE:  wane_rate_r  <= cfg_data;
        ata_pkg::REG_SAMP_TIME:  samp_time_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  ata_pkg::stat_t  stat;
  ata_pkg::ctrl_t  ctrl;
  ata_pkg::state_t state_r;
  logic            counted;
  logic            last_r;
  logic            out_valid_r;

  assign counted = in_ch.infected && (in_ch.isolation_time <= samp_time_r);

  always_comb begin
    stat.in_valid = in_ch.valid;
    stat.counted  = counted;
    stat.last_in  = in_ch.last;
    stat.last_r   = last_r;
    stat.out_free = !out_valid_r || out_ch.ready;
  end

  ata_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .state_r (state_r),
    .ctrl    (ctrl)
  );

  assign in_ch.ready = ctrl.in_ready;

  // captured item
  logic [ata_pkg::TIME_W-1:0]   elapsed_r;
  logic [ata_pkg::MAP_W-1:0]    map_long_r;
  logic [ata_pkg::MAP_W-1:0]    map_short_r;
  logic [ata_pkg::STRAIN_W-1:0] strain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (ctrl.capture) begin
      last_r <= in_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      elapsed_r   <= samp_time_r - in_ch.isolation_time;
      map_long_r  <= in_ch.map_long;
      map_short_r <= in_ch.map_short;
      strain_r    <= in_ch.tested_strain;
    end
  end

  // shared multiplier and its operand selection
  logic [ata_pkg::MUL_A_W-1:0] op_a;
  logic [ata_pkg::MUL_B_W-1:0] op_b;
  logic [ata_pkg::PROD_W-1:0]  prod_r;
  logic [ata_pkg::FRAC_W-1:0]  sen_r;
  logic [ata_pkg::FRAC_W-1:0]  wan_r;
  logic [31:0]                 lt_r;
  logic [ata_pkg::COUNT_W-1:0] count_r;

  always_comb begin
    case (ctrl.op)
      ata_pkg::OP_SEN: begin
        op_a = ata_pkg::MUL_A_W'(count_r);
        op_b = ata_pkg::MUL_B_W'(sen_rate_r);
      end
      ata_pkg::OP_WAN: begin
        op_a = ata_pkg::MUL_A_W'(elapsed_r);
        op_b = ata_pkg::MUL_B_W'(wane_rate_r);
      end
      ata_pkg::OP_LT: begin
        op_a = ata_pkg::MUL_A_W'(map_long_r);
        op_b = ata_pkg::MUL_B_W'(long_gain_r);
      end
      ata_pkg::OP_SGMS: begin
        op_a = ata_pkg::MUL_A_W'(map_short_r);
        op_b = ata_pkg::MUL_B_W'(short_gain_r);
      end
      ata_pkg::OP_ST: begin
        // short gain * map short, times waning
        op_a = ata_pkg::MUL_A_W'(prod_r[31:0]);
        op_b = wan_r;
      end
      ata_pkg::OP_FIN: begin
        // long term plus short term (Q4.44 down to Q4.28), times seniority
        op_a = ata_pkg::MUL_A_W'(lt_r) + ata_pkg::MUL_A_W'(prod_r[47:16]);
        op_b = sen_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ata_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  always_ff @(posedge clk) begin
    if (ctrl.sen_ld) begin
      sen_r <= ata_pkg::clamp_one_minus(prod_r[31:0]);
    end
    if (ctrl.wan_ld) begin
      wan_r <= ata_pkg::clamp_one_minus(prod_r[31:0]);
    end
    if (ctrl.lt_ld) begin
      lt_r <= prod_r[31:0];
    end
  end

  // accumulation
  logic [ata_pkg::TITRE_W-1:0]   titre_sum_r;
  logic [ata_pkg::TITRE_W-1:0]   titre_sum_nxt;
  logic [ata_pkg::COUNT_W-1:0]   count_nxt;
  logic [ata_pkg::CONTRIB_W-1:0] contrib;
  logic [ata_pkg::TITRE_W:0]     sum_wide;

  assign contrib  = prod_r[ata_pkg::PROD_W-1:32];
  assign sum_wide = {1'b0, titre_sum_r} + (ata_pkg::TITRE_W + 1)'(contrib);

  always_comb begin
    titre_sum_nxt = titre_sum_r;
    count_nxt     = count_r;
    if (ctrl.emit) begin
      titre_sum_nxt = '0;
      count_nxt     = '0;
    end else if (ctrl.acc_ld) begin
      titre_sum_nxt = sum_wide[ata_pkg::TITRE_W] ? ata_pkg::TITRE_MAX
                                                 : sum_wide[ata_pkg::TITRE_W-1:0];
      if (count_r != ata_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      titre_sum_r <= '0;
      count_r     <= '0;
    end else begin
      titre_sum_r <= titre_sum_nxt;
      count_r     <= count_nxt;
    end
  end

  // output register
  logic [ata_pkg::TITRE_W-1:0]  out_titre_r;
  logic [ata_pkg::STRAIN_W-1:0] out_strain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_titre_r  <= titre_sum_r;
      out_strain_r <= strain_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.titre        = out_titre_r;
  assign out_ch.titre_strain = out_strain_r;

  // checks
  a_skip_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !counted && !in_ch.last) |=> in_ch.ready)
    else $error("item that does not count did not return to idle");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> (titre_sum_r == '0 && count_r == '0 && out_valid_r))
    else $error("run state not cleared on emit");

  a_contrib_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ata_pkg::S_ACC) |-> !prod_r[ata_pkg::PROD_W-1])
    else $error("contribution exceeds its range");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !ctrl.emit)
    else $error("output register overwritten while stalled");

endmodule
